// ===== rtl/hci_pkg.sv =====
`default_nettype none

package hci_pkg;

   // configuration register indexes
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_ADDR_W-1:0] CSR_DIMS  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORDER = 1'd1;

   localparam logic [CSR_DATA_W-1:0] DIMS_RESET  = 4'd2;
   localparam logic [CSR_DATA_W-1:0] ORDER_RESET = 4'd8;

   // per-stage tag that travels alongside the coordinate words
   typedef struct packed {
      logic valid;
      logic err;
   } hci_tag_type;

endpackage

`default_nettype wire

// ===== rtl/hci_cell.sv =====
`default_nettype none

// One bit plane of the inverse undo: invert or exchange the bits below PLANE.
module hci_cell import hci_pkg::*; #(
   parameter int MAX_DIMS   = 8,
   parameter int COORD_BITS = 8,
   parameter int PLANE      = 1,
   parameter int NW         = 4,
   parameter int PW         = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [NW-1:0]                         dims_n,
   input  wire logic [PW-1:0]                         order_p,
   input  wire hci_tag_type                           up_tag,
   output logic                                       up_ready,
   input  wire logic [MAX_DIMS-1:0][COORD_BITS-1:0]   up_x,
   output hci_tag_type                                dn_tag,
   input  wire logic                                  dn_ready,
   output logic [MAX_DIMS-1:0][COORD_BITS-1:0]        dn_x
);

   localparam logic [COORD_BITS-1:0] MASK = COORD_BITS'((1 << PLANE) - 1);

   hci_tag_type                            tag_ff;
   logic [MAX_DIMS-1:0][COORD_BITS-1:0]    x_ff;
   logic [MAX_DIMS-1:0][COORD_BITS-1:0]    x_in;

   always_comb begin
      logic [COORD_BITS-1:0] t;
      x_in = up_x;
      t    = '0;
      if (PLANE < int'(order_p)) begin
         for (int i = 0; i < MAX_DIMS; i++) begin
            if (i < int'(dims_n)) begin
               if (x_in[i][PLANE]) begin
                  x_in[0] = x_in[0] ^ MASK;
               end else begin
                  t       = (x_in[0] ^ x_in[i]) & MASK;
                  x_in[0] = x_in[0] ^ t;
                  x_in[i] = x_in[i] ^ t;
               end
            end
         end
      end
   end

   assign up_ready = !tag_ff.valid || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (up_ready) begin
         tag_ff <= up_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_tag.valid) begin
         x_ff <= x_in;
      end
   end

   assign dn_tag = tag_ff;
   assign dn_x   = x_ff;

endmodule

`default_nettype wire

// ===== rtl/hci_gray.sv =====
`default_nettype none

// Gray encode across dimensions, then apply the correction mask of the last dimension.
module hci_gray import hci_pkg::*; #(
   parameter int MAX_DIMS   = 8,
   parameter int COORD_BITS = 8,
   parameter int NW         = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [NW-1:0]                         dims_n,
   input  wire hci_tag_type                           up_tag,
   output logic                                       up_ready,
   input  wire logic [MAX_DIMS-1:0][COORD_BITS-1:0]   up_x,
   output hci_tag_type                                dn_tag,
   input  wire logic                                  dn_ready,
   output logic [MAX_DIMS-1:0][COORD_BITS-1:0]        dn_x
);

   hci_tag_type                            tag_ff;
   logic [MAX_DIMS-1:0][COORD_BITS-1:0]    x_ff;
   logic [MAX_DIMS-1:0][COORD_BITS-1:0]    x_in;

   always_comb begin
      logic [COORD_BITS-1:0] last;
      logic [COORD_BITS-1:0] t;
      x_in = up_x;
      last = '0;
      t    = '0;
      for (int i = 1; i < MAX_DIMS; i++) begin
         if (i < int'(dims_n)) begin
            x_in[i] = x_in[i] ^ x_in[i-1];
         end
      end
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (i == int'(dims_n) - 1) begin
            last = x_in[i];
         end
      end
      // bits at or above the order are zero for in-range points
      for (int b = 1; b < COORD_BITS; b++) begin
         if (last[b]) begin
            t = t ^ COORD_BITS'((1 << b) - 1);
         end
      end
      for (int i = 0; i < MAX_DIMS; i++) begin
         x_in[i] = x_in[i] ^ t;
      end
   end

   assign up_ready = !tag_ff.valid || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (up_ready) begin
         tag_ff <= up_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_tag.valid) begin
         x_ff <= x_in;
      end
   end

   assign dn_tag = tag_ff;
   assign dn_x   = x_ff;

endmodule

`default_nettype wire

// ===== rtl/hci_pack.sv =====
`default_nettype none

// Interleave the transposed words into the index (zero for an out-of-range point) and hold it in the output register.
module hci_pack import hci_pkg::*; #(
   parameter int MAX_DIMS   = 8,
   parameter int COORD_BITS = 8,
   parameter int NW         = 4,
   parameter int PW         = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [NW-1:0]                         dims_n,
   input  wire logic [PW-1:0]                         order_p,
   input  wire hci_tag_type                           up_tag,
   output logic                                       up_ready,
   input  wire logic [MAX_DIMS-1:0][COORD_BITS-1:0]   up_x,
   output hci_tag_type                                dn_tag,
   input  wire logic                                  dn_ready,
   output logic [MAX_DIMS*COORD_BITS-1:0]             dn_index
);

   localparam int IDX_W = MAX_DIMS * COORD_BITS;
   localparam int SW    = $clog2(IDX_W + 1);

   hci_tag_type               tag_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic [IDX_W-1:0]          idx_in;

   always_comb begin
      logic [MAX_DIMS-1:0] pl;
      logic [MAX_DIMS-1:0] sel;
      logic [SW-1:0]       sh;
      idx_in = '0;
      for (int b = 0; b < COORD_BITS; b++) begin
         for (int i = 0; i < MAX_DIMS; i++) begin
            pl[MAX_DIMS-1-i] = up_x[i][b];
         end
         // dimension 0 lands in the top bit of each plane
         sel = pl >> (MAX_DIMS - int'(dims_n));
         sh  = SW'(b * int'(dims_n));
         if (b < int'(order_p)) begin
            idx_in = idx_in | (IDX_W'(sel) << sh);
         end
      end
      if (up_tag.err) begin
         idx_in = '0;
      end
   end

   assign up_ready = !tag_ff.valid || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (up_ready) begin
         tag_ff <= up_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_tag.valid) begin
         idx_ff <= idx_in;
      end
   end

   assign dn_tag   = tag_ff;
   assign dn_index = idx_ff;

endmodule

`default_nettype wire

// ===== rtl/hilbert_coordinates_to_index.sv =====
// Hilbert curve index of a point, one bit-plane cell per coordinate bit above bit 0.
// Pipeline stages between req accept and rsp_tvalid:
//   COORD_BITS-1 plane cells, one Gray/correction stage, one interleave/output stage.
// Throughput: one item per cycle while rsp_tready is high; a full stage holds only while its successor cannot accept.
// Reset (synchronous, active high) empties all stages and sets dims to 2, order to 8.
`default_nettype none

module hilbert_coordinates_to_index import hci_pkg::*; #(
   parameter int MAX_DIMS   = 8,
   parameter int COORD_BITS = 8
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   // coord_0 .. coord_(MAX_DIMS-1), COORD_BITS each, coord_0 lowest
   input  wire logic [((MAX_DIMS*COORD_BITS+7)/8)*8-1:0]  req_tdata,
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   // curve_index
   output logic [((MAX_DIMS*COORD_BITS+7)/8)*8-1:0]       rsp_tdata,
   // range_error
   output logic                                           rsp_tuser,
   input  wire logic                                      csr_we,
   input  wire logic [CSR_ADDR_W-1:0]                     csr_addr,
   input  wire logic [CSR_DATA_W-1:0]                     csr_wdata
);

   localparam int IDX_W  = MAX_DIMS * COORD_BITS;
   localparam int OUT_W  = ((IDX_W + 7) / 8) * 8;
   localparam int NW     = $clog2(MAX_DIMS + 1);
   localparam int PW     = $clog2(COORD_BITS + 1);
   localparam int NCELL  = COORD_BITS - 1;

   logic [NW-1:0] dims_ff;
   logic [NW-1:0] dims_in;
   logic [PW-1:0] order_ff;
   logic [PW-1:0] order_in;

   function automatic logic [CSR_DATA_W-1:0] clamp(input logic [CSR_DATA_W-1:0] v,
                                                    input int hi);
      logic [CSR_DATA_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CSR_DATA_W'(1);
      end else if (int'(v) > hi) begin
         r = CSR_DATA_W'(hi);
      end
      return r;
   endfunction

   // registers hold the saturated values
   always_comb begin
      dims_in  = dims_ff;
      order_in = order_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_DIMS:  dims_in  = NW'(clamp(csr_wdata, MAX_DIMS));
            CSR_ORDER: order_in = PW'(clamp(csr_wdata, COORD_BITS));
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff  <= NW'(clamp(DIMS_RESET, MAX_DIMS));
         order_ff <= PW'(clamp(ORDER_RESET, COORD_BITS));
      end else begin
         dims_ff  <= dims_in;
         order_ff <= order_in;
      end
   end

   hci_tag_type                          s_tag   [NCELL+1];
   logic                                 s_ready [NCELL+1];
   logic [MAX_DIMS-1:0][COORD_BITS-1:0]  s_x     [NCELL+1];
   logic                                 range_err;

   always_comb begin
      range_err = 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (i < int'(dims_ff) && (s_x[0][i] >> order_ff) != '0) begin
            range_err = 1'b1;
         end
      end
   end

   assign s_x[0]         = req_tdata[IDX_W-1:0];
   assign s_tag[0].valid = req_tvalid;
   assign s_tag[0].err   = range_err;
   assign req_tready     = s_ready[0];

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      hci_cell #(
         .MAX_DIMS   (MAX_DIMS),
         .COORD_BITS (COORD_BITS),
         .PLANE      (COORD_BITS - 1 - k),
         .NW         (NW),
         .PW         (PW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .dims_n   (dims_ff),
         .order_p  (order_ff),
         .up_tag   (s_tag[k]),
         .up_ready (s_ready[k]),
         .up_x     (s_x[k]),
         .dn_tag   (s_tag[k+1]),
         .dn_ready (s_ready[k+1]),
         .dn_x     (s_x[k+1])
      );
   end

   hci_tag_type                          g_tag;
   logic                                 g_ready;
   logic [MAX_DIMS-1:0][COORD_BITS-1:0]  g_x;
   hci_tag_type                          o_tag;
   logic [IDX_W-1:0]                     o_index;

   hci_gray #(
      .MAX_DIMS   (MAX_DIMS),
      .COORD_BITS (COORD_BITS),
      .NW         (NW)
   ) u_gray (
      .clock    (clock),
      .reset    (reset),
      .dims_n   (dims_ff),
      .up_tag   (s_tag[NCELL]),
      .up_ready (s_ready[NCELL]),
      .up_x     (s_x[NCELL]),
      .dn_tag   (g_tag),
      .dn_ready (g_ready),
      .dn_x     (g_x)
   );

   hci_pack #(
      .MAX_DIMS   (MAX_DIMS),
      .COORD_BITS (COORD_BITS),
      .NW         (NW),
      .PW         (PW)
   ) u_pack (
      .clock    (clock),
      .reset    (reset),
      .dims_n   (dims_ff),
      .order_p  (order_ff),
      .up_tag   (g_tag),
      .up_ready (g_ready),
      .up_x     (g_x),
      .dn_tag   (o_tag),
      .dn_ready (rsp_tready),
      .dn_index (o_index)
   );

   assign rsp_tvalid = o_tag.valid;
   assign rsp_tuser  = o_tag.err;
   assign rsp_tdata  = OUT_W'(o_index);

endmodule

`default_nettype wire

// ===== rtl/hci_checker.sv =====
`default_nettype none

module hci_checker #(
   parameter int OUT_W = 64
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [OUT_W-1:0]  rsp_tdata,
   input wire logic              rsp_tuser
);

   // reset empties the output stage
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // an out-of-range point always reports index zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("range error with nonzero index");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

endmodule

bind hilbert_coordinates_to_index hci_checker #(
   .OUT_W (OUT_W)
) u_hci_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== dv/tb_hilbert_coordinates_to_index.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_hilbert_coordinates_to_index;
   import hci_pkg::*;

   localparam int NUM_DIMS      = 8;
   localparam int COORD_W       = 8;
   localparam int POINT_W       = ((NUM_DIMS*COORD_W+7)/8)*8;
   localparam int SETTLE_CYCLES = 14;
   localparam int HOLD_CYCLES   = 150;
   localparam int WATCHDOG_MAX  = 2000;
   localparam int PHASE_ITEMS   = 95;

   typedef struct packed {
      logic [POINT_W-1:0] curve_index;
      logic               range_error;
   } curve_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [POINT_W-1:0]    req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [POINT_W-1:0]    rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // shadow of the block's registers
   logic [CSR_DATA_W-1:0] cfg_dims;
   logic [CSR_DATA_W-1:0] cfg_order;

   curve_result_type expected_index[$];
   int               error_count;
   int               idle_cycles;
   bit               sender_eager;
   bit               hold_request;
   bit               send_quiet;
   int               send_run;

   hilbert_coordinates_to_index dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int unsigned eff_dims();
      if (cfg_dims == 0) return 1;
      if (cfg_dims > NUM_DIMS) return NUM_DIMS;
      return 32'(cfg_dims);
   endfunction

   function automatic int unsigned eff_order();
      if (cfg_order == 0) return 1;
      if (cfg_order > COORD_W) return COORD_W;
      return 32'(cfg_order);
   endfunction

   function automatic curve_result_type hilbert_predict(input logic [POINT_W-1:0] point);
      int unsigned      n, p, i, b, top, q, mask, t, maxc;
      int unsigned      x [NUM_DIMS];
      curve_result_type res;
      n = eff_dims();
      p = eff_order();
      maxc = (1 << p) - 1;
      res.curve_index = '0;
      res.range_error = 1'b0;
      for (i = 0; i < n; i++) begin
         x[i] = 32'(point[i*COORD_W +: COORD_W]);
         if (x[i] > maxc) res.range_error = 1'b1;
      end
      if (res.range_error) return res;
      top = 1 << (p - 1);
      // undo pass: invert low bits of dimension 0 or swap them with dimension i
      for (q = top; q > 1; q = q >> 1) begin
         mask = q - 1;
         for (i = 0; i < n; i++) begin
            if ((x[i] & q) != 0) begin
               x[0] = x[0] ^ mask;
            end else begin
               t = (x[0] ^ x[i]) & mask;
               x[0] = x[0] ^ t;
               x[i] = x[i] ^ t;
            end
         end
      end
      for (i = 1; i < n; i++) x[i] = x[i] ^ x[i-1];
      t = 0;
      for (q = top; q > 1; q = q >> 1)
         if ((x[n-1] & q) != 0) t = t ^ (q - 1);
      for (i = 0; i < n; i++) x[i] = x[i] ^ t;
      // interleave planes from the top, dimension 0 first
      for (b = p; b > 0; b--) begin
         for (i = 0; i < n; i++)
            res.curve_index = {res.curve_index[POINT_W-2:0], 1'((x[i] >> (b - 1)) & 1)};
      end
      return res;
   endfunction

   function automatic logic [POINT_W-1:0] random_point();
      int unsigned        n, p, i;
      logic [POINT_W-1:0] pt;
      n = eff_dims();
      p = eff_order();
      for (i = 0; i < NUM_DIMS; i++) begin
         if (i < n) pt[i*COORD_W +: COORD_W] = COORD_W'($urandom_range(0, (1 << p) - 1));
         else pt[i*COORD_W +: COORD_W] = COORD_W'($urandom_range(0, 255));
      end
      // push a used coordinate to an edge of its range now and then
      if ($urandom_range(0, 7) == 0) begin
         i = $urandom_range(0, n - 1);
         pt[i*COORD_W +: COORD_W] = $urandom_range(0, 1) ? COORD_W'((1 << p) - 1) : '0;
      end
      if (p < COORD_W && $urandom_range(0, 9) == 0) begin
         i = $urandom_range(0, n - 1);
         pt[i*COORD_W +: COORD_W] = COORD_W'($urandom_range(1 << p, 255));
      end
      return pt;
   endfunction

   function automatic int next_send_gap();
      if (send_run == 0) begin
         send_quiet = ($urandom_range(0, 2) == 0);
         send_run = $urandom_range(8, 40);
      end
      send_run--;
      if (sender_eager || send_quiet) return 0;
      return $urandom_range(0, 5);
   endfunction

   // drive one register write; the caller drops csr_we afterwards
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      if (addr == CSR_DIMS) cfg_dims = value;
      else if (addr == CSR_ORDER) cfg_order = value;
   endtask

   task automatic set_shape(input logic [CSR_DATA_W-1:0] dims,
                            input logic [CSR_DATA_W-1:0] order);
      write_csr(CSR_DIMS, dims);
      write_csr(CSR_ORDER, order);
      csr_we <= 1'b0;
   endtask

   task automatic send_point(input logic [POINT_W-1:0] point);
      int gap;
      gap = next_send_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= point;
      do @(posedge clock); while (!req_tready);
      expected_index.push_back(hilbert_predict(point));
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_index.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      // reset shape: dims 2, order 8
      send_point('0);
      send_point(64'h0000_0000_0000_FFFF);
      send_point(64'h0000_0000_0000_00FF);
      send_point(64'h0000_0000_0000_FF00);
      // unused coordinates are ignored
      send_point(64'hFFFF_FFFF_FFFF_0180);
      drain();
      set_shape(4'd8, 4'd8);
      send_point(64'hFFFF_FFFF_FFFF_FFFF);
      send_point(64'hAA55_AA55_AA55_AA55);
      send_point(64'h8000_0000_0000_0001);
      send_point(64'h0102_0408_1020_4080);
      drain();
      set_shape(4'd8, 4'd1);
      send_point(64'h0101_0101_0101_0101);
      send_point(64'h0100_0100_0001_0001);
      send_point(64'h0000_0000_0200_0000);
      drain();
      set_shape(4'd1, 4'd1);
      send_point(64'hFFFF_FFFF_FFFF_FF00);
      send_point(64'hFFFF_FFFF_FFFF_FF01);
      send_point(64'h0000_0000_0000_0002);
      drain();
      // zero and oversized register values saturate
      set_shape(4'd0, 4'd0);
      send_point(64'h0000_0000_0000_0001);
      send_point(64'h0000_0000_0000_0003);
      drain();
      set_shape(4'd15, 4'd15);
      send_point(64'hFFFF_FFFF_FFFF_FFFF);
      send_point(64'h1234_5678_9ABC_DEF0);
      drain();
      // boundary of the coordinate range at order 3
      set_shape(4'd3, 4'd3);
      send_point(64'hFFFF_FFFF_FF07_0707);
      send_point(64'h0000_0000_0008_0000);
      send_point(64'h0000_0000_0000_0605);
      drain();
   endtask

   task automatic test_random_shapes();
      logic [CSR_DATA_W-1:0] dims_list  [12];
      logic [CSR_DATA_W-1:0] order_list [12];
      int                    k, j;
      dims_list[0] = 4'd1;  order_list[0] = 4'd1;
      dims_list[1] = 4'd8;  order_list[1] = 4'd8;
      dims_list[2] = 4'd1;  order_list[2] = 4'd8;
      dims_list[3] = 4'd8;  order_list[3] = 4'd1;
      dims_list[4] = 4'd0;  order_list[4] = 4'd0;
      dims_list[5] = 4'd15; order_list[5] = 4'd15;
      for (k = 6; k < 12; k++) begin
         dims_list[k]  = CSR_DATA_W'($urandom_range(0, 15));
         order_list[k] = CSR_DATA_W'($urandom_range(0, 15));
      end
      for (k = 0; k < 12; k++) begin
         set_shape(dims_list[k], order_list[k]);
         for (j = 0; j < PHASE_ITEMS; j++) send_point(random_point());
         drain();
      end
   endtask

   // stall the result side long enough to back up the pipeline
   task automatic test_backpressure();
      int j;
      set_shape(4'd5, 4'd6);
      sender_eager = 1'b1;
      hold_request = 1'b1;
      for (j = 0; j < 60; j++) send_point(random_point());
      sender_eager = 1'b0;
      drain();
   endtask

   // result side: random stalls, quiet stretches and one long hold-off
   initial begin : result_sink
      int  stall;
      int  run;
      bit  quiet;
      run = 0;
      quiet = 1'b0;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (run == 0) begin
            quiet = ($urandom_range(0, 2) == 0);
            run = $urandom_range(8, 40);
         end
         run--;
         stall = quiet ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      curve_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_index.size() == 0) begin
            $display("%0t: unexpected item: actual index %h error %b",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            exp_res = expected_index.pop_front();
            if (rsp_tdata !== exp_res.curve_index) begin
               $display("%0t: curve_index mismatch: expected %h actual %h",
                        $time, exp_res.curve_index, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== exp_res.range_error) begin
               $display("%0t: range_error mismatch: expected %b actual %b",
                        $time, exp_res.range_error, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("FAIL hilbert_coordinates_to_index");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      cfg_dims     = DIMS_RESET;
      cfg_order    = ORDER_RESET;
      error_count  = 0;
      idle_cycles  = 0;
      sender_eager = 1'b0;
      hold_request = 1'b0;
      send_quiet   = 1'b0;
      send_run     = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_shapes();
      test_backpressure();
      drain();
      if (error_count == 0) begin
         $display("PASS hilbert_coordinates_to_index");
      end else begin
         $display("FAIL hilbert_coordinates_to_index");
      end
      $finish;
   end

endmodule

`default_nettype wire
